@@ src/swing_foot_cycloid_trajectory_macros.svh @@
// swing_foot_cycloid_trajectory_macros.svh
// Concurrent assertion macros for the swing foot trajectory RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef SWING_FOOT_CYCLOID_TRAJECTORY_MACROS_SVH
`define SWING_FOOT_CYCLOID_TRAJECTORY_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, sampled on the clock, off during reset
`define SFCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// same-cycle implication
`define SFCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define SFCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SFCT_ASSERT(lbl, clk, rst_n, prop)
`define SFCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SFCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/sfct_pkg.sv @@
// sfct_pkg.sv
// Types, codes and fixed-point constants of the swing foot trajectory block.
// No dependencies; imported by every module of the block but sfct_ram.
package sfct_pkg;

    // field widths
    localparam int POS_W  = 24;
    localparam int VEL_W  = 32;
    localparam int TRIG_W = 18;     // signed sine/cosine, Q1.16 plus sign

    // item kinds
    localparam logic KIND_UPDATE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W          = 1;
    localparam logic CFG_STEP_HEIGHT    = 1'b0;
    localparam logic CFG_INV_SWING_TIME = 1'b1;
    localparam int   CFG_DATA_W         = 24;

    localparam logic [15:0] STEP_HEIGHT_RST    = 16'd3277;
    localparam logic [23:0] INV_SWING_TIME_RST = 24'd655360;

    // arithmetic constants
    localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0]        ONE_Q30     = 64'd1073741824;
    localparam logic signed [18:0] INV_2PI_Q20 = 19'sd166886;
    localparam logic signed [18:0] PI_Q16      = 19'sd205887;
    localparam logic [15:0]        QUARTER_TURN = 16'd16384;

    // input transaction
    typedef struct packed {
        logic                    kind;
        logic [1:0]              leg;
        logic                    is_swing;
        logic [15:0]             phase;
        logic signed [POS_W-1:0] now_x;
        logic signed [POS_W-1:0] now_y;
        logic signed [POS_W-1:0] now_z;
        logic signed [POS_W-1:0] land_x;
        logic signed [POS_W-1:0] land_y;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [1:0]              out_leg;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
    } t_out;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0] step_height;
        logic [23:0] inv_swing_time;
    } t_cfg;

    // operands handed to the arithmetic pipe
    typedef struct packed {
        logic [1:0]               leg;
        logic                     is_swing;
        logic [15:0]              phase;
        logic signed [POS_W-1:0]  start_x;
        logic signed [POS_W-1:0]  start_y;
        logic signed [POS_W-1:0]  start_z;
        logic signed [POS_W-1:0]  land_x;
        logic signed [POS_W-1:0]  land_y;
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_arith_in;

endpackage

@@ src/sfct_ram.sv @@
// sfct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sfct_sine_lut.sv @@
// sfct_sine_lut.sv
// Quarter-wave sine table with two registered read ports (sine and cosine).
// Depends on sfct_pkg; table contents are built at elaboration.
module sfct_sine_lut #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic [15:0]                       i_phase,
    output logic signed [sfct_pkg::TRIG_W-1:0] o_sin,
    output logic signed [sfct_pkg::TRIG_W-1:0] o_cos
);

    import sfct_pkg::*;

    localparam int TAB_N = SINE_ENTRIES + 1;
    localparam int AW    = $clog2(SINE_ENTRIES + 1);
    localparam int PW    = 14 + AW;

    typedef logic [16:0] t_tab [TAB_N];

    // sin(pi/2 * k / SINE_ENTRIES) by a 9th-order Taylor series in Q2.30
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int k = 0; k < TAB_N; k++) begin
            x  = (PI_HALF_Q30 * 64'(k)) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            tab[k] = 17'((((x * t) >> 30) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // quadrant fold: odd quadrants read the table backwards
    function automatic logic [AW-1:0] fold_addr(input logic [15:0] ph);
        logic [PW-1:0] prod;
        logic [AW-1:0] idx;
        prod = PW'(ph[13:0]) * PW'(SINE_ENTRIES);
        idx  = AW'(prod >> 14);
        if (ph[14]) begin
            return AW'(SINE_ENTRIES) - idx;
        end
        return idx;
    endfunction

    logic [15:0]   w_cos_phase;
    logic [AW-1:0] w_sin_addr;
    logic [AW-1:0] w_cos_addr;
    logic [16:0]   r_sin_mag;
    logic [16:0]   r_cos_mag;
    logic          r_sin_neg;
    logic          r_cos_neg;

    assign w_cos_phase = i_phase + QUARTER_TURN;
    assign w_sin_addr  = fold_addr(i_phase);
    assign w_cos_addr  = fold_addr(w_cos_phase);

    // registered table reads, sign from the upper half turn
    always_ff @(posedge i_clk) begin
        r_sin_mag <= SINE_TAB[w_sin_addr];
        r_cos_mag <= SINE_TAB[w_cos_addr];
        r_sin_neg <= i_phase[15];
        r_cos_neg <= w_cos_phase[15];
    end

    assign o_sin = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
    assign o_cos = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});

endmodule

@@ src/sfct_arith.sv @@
// sfct_arith.sv
// Six-stage fixed-latency cycloid arithmetic: positions, velocities, saturation.
// Depends on sfct_pkg.
module sfct_arith (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfct_pkg::t_cfg        i_cfg,
    input  logic                  i_launch,
    input  sfct_pkg::t_arith_in   i_op,
    output logic                  o_done,
    output sfct_pkg::t_out        o_res
);

    import sfct_pkg::*;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [27:0] v);
        if (v > 28'sd8388607) begin
            return 24'sd8388607;
        end
        if (v < -28'sd8388608) begin
            return -24'sd8388608;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[VEL_W-1:0];
    endfunction

    logic [5:0] r_vld;

    // stage 0: operand differences
    logic [1:0]               r_s0_leg;
    logic                     r_s0_swing;
    logic [15:0]              r_s0_phase;
    logic signed [POS_W-1:0]  r_s0_sx, r_s0_sy, r_s0_sz;
    logic signed [24:0]       r_s0_dx, r_s0_dy;
    logic signed [TRIG_W-1:0] r_s0_s;
    logic signed [18:0]       r_s0_omc;
    // stage 1: first products
    logic [1:0]               r_s1_leg;
    logic                     r_s1_swing;
    logic [15:0]              r_s1_phase;
    logic signed [POS_W-1:0]  r_s1_sx, r_s1_sy, r_s1_sz;
    logic signed [24:0]       r_s1_dx, r_s1_dy;
    logic signed [34:0]       r_s1_sk;
    logic signed [42:0]       r_s1_mx, r_s1_my;
    logic signed [33:0]       r_s1_mhz, r_s1_mhs;
    // stage 2: cycloid angle term, rounded velocity factors
    logic [1:0]               r_s2_leg;
    logic                     r_s2_swing;
    logic signed [POS_W-1:0]  r_s2_sx, r_s2_sy;
    logic signed [24:0]       r_s2_dx, r_s2_dy, r_s2_pz;
    logic signed [37:0]       r_s2_g;
    logic signed [26:0]       r_s2_rx, r_s2_ry;
    logic signed [51:0]       r_s2_mzp;
    // stage 3: split position products, velocity products
    logic [1:0]               r_s3_leg;
    logic                     r_s3_swing;
    logic signed [POS_W-1:0]  r_s3_sx, r_s3_sy;
    logic signed [24:0]       r_s3_pz;
    logic signed [44:0]       r_s3_pxl, r_s3_pxh, r_s3_pyl, r_s3_pyh;
    logic signed [51:0]       r_s3_vxp, r_s3_vyp;
    logic signed [19:0]       r_s3_rz;
    // stage 4: recombine, z velocity product
    logic [1:0]               r_s4_leg;
    logic                     r_s4_swing;
    logic signed [POS_W-1:0]  r_s4_sx, r_s4_sy;
    logic signed [24:0]       r_s4_pz;
    logic signed [62:0]       r_s4_pxp, r_s4_pyp;
    logic signed [35:0]       r_s4_vx, r_s4_vy;
    logic signed [44:0]       r_s4_vzp;
    // stage 5: result
    t_out                     r_res;

    logic signed [42:0] w_mx_rnd, w_my_rnd;
    logic signed [33:0] w_hz_rnd;
    logic signed [24:0] w_pz_sw;
    logic signed [51:0] w_mzp_rnd;
    logic signed [19:0] w_gl, w_gh;
    logic signed [24:0] w_inv;
    logic signed [16:0] w_h;
    logic signed [51:0] w_vxp_rnd, w_vyp_rnd;
    logic signed [62:0] w_pxp_rnd, w_pyp_rnd;
    logic signed [44:0] w_vzp_rnd;
    logic signed [27:0] w_px, w_py;
    logic signed [35:0] w_vz;

    assign w_h   = $signed({1'b0, i_cfg.step_height});
    assign w_inv = $signed({1'b0, i_cfg.inv_swing_time});

    // rounding: add half, then arithmetic shift (ties toward +inf)
    assign w_mx_rnd  = r_s1_mx + 43'sd32768;
    assign w_my_rnd  = r_s1_my + 43'sd32768;
    assign w_hz_rnd  = r_s1_mhz + 34'sd65536;
    assign w_pz_sw   = 25'(r_s1_sz) + 25'(w_hz_rnd >>> 17);
    assign w_mzp_rnd = r_s2_mzp + 52'sh80000000;
    // angle term split: signed upper part, unsigned lower 19 bits
    assign w_gl      = $signed({1'b0, r_s2_g[18:0]});
    assign w_gh      = 20'(r_s2_g >>> 19);
    assign w_vxp_rnd = r_s3_vxp + 52'sd32768;
    assign w_vyp_rnd = r_s3_vyp + 52'sd32768;
    assign w_pxp_rnd = r_s4_pxp + 63'sh800000000;
    assign w_pyp_rnd = r_s4_pyp + 63'sh800000000;
    assign w_vzp_rnd = r_s4_vzp + 45'sd32768;
    assign w_px      = 28'(r_s4_sx) + 28'(w_pxp_rnd >>> 36);
    assign w_py      = 28'(r_s4_sy) + 28'(w_pyp_rnd >>> 36);
    assign w_vz      = 36'(w_vzp_rnd >>> 16);

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_launch};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_launch) begin
            r_s0_leg   <= i_op.leg;
            r_s0_swing <= i_op.is_swing;
            r_s0_phase <= i_op.phase;
            r_s0_sx    <= i_op.start_x;
            r_s0_sy    <= i_op.start_y;
            r_s0_sz    <= i_op.start_z;
            r_s0_dx    <= 25'(i_op.land_x) - 25'(i_op.start_x);
            r_s0_dy    <= 25'(i_op.land_y) - 25'(i_op.start_y);
            r_s0_s     <= i_op.sin_v;
            r_s0_omc   <= 19'sd65536 - 19'(i_op.cos_v);
        end
        if (r_vld[0]) begin
            r_s1_leg   <= r_s0_leg;
            r_s1_swing <= r_s0_swing;
            r_s1_phase <= r_s0_phase;
            r_s1_sx    <= r_s0_sx;
            r_s1_sy    <= r_s0_sy;
            r_s1_sz    <= r_s0_sz;
            r_s1_dx    <= r_s0_dx;
            r_s1_dy    <= r_s0_dy;
            r_s1_sk    <= 35'(r_s0_s) * 35'(INV_2PI_Q20);
            r_s1_mx    <= 43'(r_s0_dx) * 43'(r_s0_omc);
            r_s1_my    <= 43'(r_s0_dy) * 43'(r_s0_omc);
            r_s1_mhz   <= 34'(w_h) * 34'(r_s0_omc);
            r_s1_mhs   <= 34'(w_h) * 34'(r_s0_s);
        end
        if (r_vld[1]) begin
            r_s2_leg   <= r_s1_leg;
            r_s2_swing <= r_s1_swing;
            r_s2_sx    <= r_s1_sx;
            r_s2_sy    <= r_s1_sy;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
            r_s2_pz    <= r_s1_swing ? w_pz_sw : 25'(r_s1_sz);
            r_s2_g     <= $signed({2'b00, r_s1_phase, 20'd0}) - 38'(r_s1_sk);
            r_s2_rx    <= 27'(w_mx_rnd >>> 16);
            r_s2_ry    <= 27'(w_my_rnd >>> 16);
            r_s2_mzp   <= 52'(r_s1_mhs) * 52'(PI_Q16);
        end
        if (r_vld[2]) begin
            r_s3_leg   <= r_s2_leg;
            r_s3_swing <= r_s2_swing;
            r_s3_sx    <= r_s2_sx;
            r_s3_sy    <= r_s2_sy;
            r_s3_pz    <= r_s2_pz;
            r_s3_pxl   <= 45'(r_s2_dx) * 45'(w_gl);
            r_s3_pxh   <= 45'(r_s2_dx) * 45'(w_gh);
            r_s3_pyl   <= 45'(r_s2_dy) * 45'(w_gl);
            r_s3_pyh   <= 45'(r_s2_dy) * 45'(w_gh);
            r_s3_vxp   <= 52'(r_s2_rx) * 52'(w_inv);
            r_s3_vyp   <= 52'(r_s2_ry) * 52'(w_inv);
            r_s3_rz    <= 20'(w_mzp_rnd >>> 32);
        end
        if (r_vld[3]) begin
            r_s4_leg   <= r_s3_leg;
            r_s4_swing <= r_s3_swing;
            r_s4_sx    <= r_s3_sx;
            r_s4_sy    <= r_s3_sy;
            r_s4_pz    <= r_s3_pz;
            r_s4_pxp   <= (63'(r_s3_pxh) <<< 19) + 63'(r_s3_pxl);
            r_s4_pyp   <= (63'(r_s3_pyh) <<< 19) + 63'(r_s3_pyl);
            r_s4_vx    <= 36'(w_vxp_rnd >>> 16);
            r_s4_vy    <= 36'(w_vyp_rnd >>> 16);
            r_s4_vzp   <= 45'(r_s3_rz) * 45'(w_inv);
        end
        // stance legs hold the start position at rest
        if (r_vld[4]) begin
            r_res.out_leg <= r_s4_leg;
            r_res.pos_z   <= sat_pos(28'(r_s4_pz));
            if (r_s4_swing) begin
                r_res.pos_x <= sat_pos(w_px);
                r_res.pos_y <= sat_pos(w_py);
                r_res.vel_x <= sat_vel(r_s4_vx);
                r_res.vel_y <= sat_vel(r_s4_vy);
                r_res.vel_z <= sat_vel(w_vz);
            end else begin
                r_res.pos_x <= r_s4_sx;
                r_res.pos_y <= r_s4_sy;
                r_res.vel_x <= '0;
                r_res.vel_y <= '0;
                r_res.vel_z <= '0;
            end
        end
    end

    assign o_done = r_vld[5];
    assign o_res  = r_res;

endmodule

@@ src/swing_foot_cycloid_trajectory.sv @@
// swing_foot_cycloid_trajectory.sv
// Top level: sequencer, capture flags, start-position RAM, sine table, arithmetic pipe.
// Depends on sfct_pkg, sfct_ram, sfct_sine_lut, sfct_arith and the macros header.
//
// Channel   Dir  Handshake                     Payload
// input     in   i_in_valid / o_in_ready       i_in  (t_in)
// result    out  o_out_valid / i_out_ready     o_out (t_out)
// config    in   i_cfg_we, no wait             i_cfg_idx, i_cfg_wdata
//
// An update transaction occupies the block through a start-RAM and sine table read state,
// a launch state, the six stages of the arithmetic pipe and an output load.
// Restart and out-of-range leg transactions give no result and leave the block idle.
// Synchronous active-low reset clears control and capture flags and restores the config
// defaults; the RAM needs no clearing, as no leg uses RAM data its capture did not write.
// A stalled result waits in the output register; the next transaction is taken
// meanwhile and its result waits in the pipe's last stage.
`include "swing_foot_cycloid_trajectory_macros.svh"

module swing_foot_cycloid_trajectory #(
    parameter int LEGS         = 4,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sfct_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sfct_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [sfct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfct_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import sfct_pkg::*;

    localparam int LEG_AW = (LEGS > 1) ? $clog2(LEGS) : 1;
    localparam int RAM_W  = 3 * POS_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_BUSY   = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    logic [2:0]        r_state, n_state;
    t_in               r_item;
    logic [LEGS-1:0]   r_captured, n_captured;
    t_cfg              r_cfg;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_in_acc;
    logic              w_leg_ok;
    logic [LEG_AW-1:0] w_leg_idx;
    logic              w_use_now;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [RAM_W-1:0]  w_ram_rdata;
    logic signed [TRIG_W-1:0] w_sin;
    logic signed [TRIG_W-1:0] w_cos;
    t_arith_in         w_op;
    logic              w_launch;
    logic              w_done;
    t_out              w_res;
    logic              w_out_free;
    logic              w_load;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_leg_ok   = (int'(i_in.leg) < LEGS);
    assign w_leg_idx  = LEG_AW'(r_item.leg);
    assign w_out_free = !r_out_valid || i_out_ready;

    // a stance leg early in its phase, or an uncaptured leg, takes the measured position
    assign w_use_now = !r_captured[w_leg_idx] || (!r_item.is_swing && !r_item.phase[15]);
    assign w_ram_we  = (r_state == ST_LAUNCH) && w_use_now;
    assign w_ram_re  = (r_state == ST_READ);
    assign w_launch  = (r_state == ST_LAUNCH);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_height    <= STEP_HEIGHT_RST;
            r_cfg.inv_swing_time <= INV_SWING_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_HEIGHT:    r_cfg.step_height    <= i_cfg_wdata[15:0];
                CFG_INV_SWING_TIME: r_cfg.inv_swing_time <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_captured = r_captured;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.kind == KIND_RESTART) begin
                        n_captured = '0;
                    end else if (w_leg_ok) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                n_captured[w_leg_idx] = 1'b1;
                n_state = ST_BUSY;
            end
            ST_BUSY: begin
                if (w_done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_captured  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_captured <= n_captured;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    // per-leg start positions
    sfct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (LEGS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_leg_idx),
        .i_wdata ({r_item.now_x, r_item.now_y, r_item.now_z}),
        .i_re    (w_ram_re),
        .i_raddr (w_leg_idx),
        .o_rdata (w_ram_rdata)
    );

    sfct_sine_lut #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_sine_lut (
        .i_clk   (i_clk),
        .i_phase (r_item.phase),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // operand selection at launch
    always_comb begin
        w_op.leg      = r_item.leg;
        w_op.is_swing = r_item.is_swing;
        w_op.phase    = r_item.phase;
        w_op.land_x   = r_item.land_x;
        w_op.land_y   = r_item.land_y;
        w_op.sin_v    = w_sin;
        w_op.cos_v    = w_cos;
        if (w_use_now) begin
            w_op.start_x = r_item.now_x;
            w_op.start_y = r_item.now_y;
            w_op.start_z = r_item.now_z;
        end else begin
            w_op.start_x = $signed(w_ram_rdata[3*POS_W-1:2*POS_W]);
            w_op.start_y = $signed(w_ram_rdata[2*POS_W-1:POS_W]);
            w_op.start_z = $signed(w_ram_rdata[POS_W-1:0]);
        end
    end

    sfct_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_launch (w_launch),
        .i_op     (w_op),
        .o_done   (w_done),
        .o_res    (w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `SFCT_ASSERT(a_ram_no_overlap, i_clk, i_rst_n, !(w_ram_we && w_ram_re))
    `SFCT_ASSERT_IMPLY(a_done_when_busy, i_clk, i_rst_n, w_done, r_state == ST_BUSY)
    `SFCT_ASSERT_IMPLY(a_hold_has_result, i_clk, i_rst_n, r_state == ST_HOLD, r_out_valid)
    `SFCT_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, w_in_acc && (i_in.kind == KIND_RESTART), r_captured == '0)
    `SFCT_ASSERT_NEXT(a_launch_captures, i_clk, i_rst_n, r_state == ST_LAUNCH, r_captured != '0)

endmodule
